### hw/rtl/lss_pkg.sv
package lss_pkg;

  // Endpoint coordinate width and configuration register width
  localparam int COORD_BITS = 12;
  localparam int REG_W      = 13;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = REG_W'(640);
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = REG_W'(480);

  // Centered, doubled coordinates: X = 2x - w, Y = 2y - 2h
  localparam int MAXC_W = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
  localparam int X_W    = MAXC_W + 2;
  // Endpoint difference, quarter compare, scaled slope term
  localparam int D_W    = COORD_BITS + 1;
  localparam int CMP_W  = MAXC_W + 3;
  localparam int SL_W   = COORD_BITS + 4;
  // |cross|, squared length, shared multiplier and accumulators
  localparam int CR_W   = 2 * X_W - 2;
  localparam int LEN_W  = 2 * COORD_BITS + 1;
  localparam int MUL_W  = CR_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 2 * CR_W;
  localparam int HALF_W = CR_W;
  localparam int PP_W   = HALF_W + LEN_W;
  localparam int ACC_W  = SQ_W + LEN_W;
  localparam int SEG_W  = 4 * COORD_BITS;

  // Stream word layouts
  localparam int IN_DATA_W  = ((SEG_W + 7) / 8) * 8;
  localparam int SIDE_W     = 1 + SEG_W;
  localparam int OUT_BITS   = 2 * SIDE_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_CR0,
    ST_CR1,
    ST_LEN0,
    ST_LEN1,
    ST_SQ0,
    ST_SQ1,
    ST_PA0,
    ST_PA1,
    ST_PB0,
    ST_PB1,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

endpackage

### hw/rtl/lane_segment_select.sv
// A segment word runs through ST_SEL and, unless the side, slope or degenerate checks drop it there,
//   through the cross, length, square and product steps to ST_DECIDE before the next word is taken.
// An end-of-frame word reaches out_tvalid through ST_FLUSH and the result register, later while the previous result
//   still waits on out_tready. The single shared 29x29 multiplier serves every product step.
// Reset (rst_n low, synchronous): frame 640x480, both stored choices empty, no result pending.
module lane_segment_select (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // segment channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // start_x, start_y, end_x, end_y (lowest bits first)
  input  logic [lss_pkg::IN_DATA_W-1:0]        in_tdata,
  // kind: 0 = segment, 1 = end of frame
  input  logic                                 in_tuser,
  // result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // left_found, left_start_x, left_start_y, left_end_x, left_end_y,
  // right_found, right_start_x, right_start_y, right_end_x, right_end_y, zero pad
  output logic [lss_pkg::OUT_DATA_W-1:0]       out_tdata,
  // configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lss_pkg::REG_W-1:0]            cfg_data
);

  localparam int C = lss_pkg::COORD_BITS;

  lss_pkg::state_t state_r, state_nxt;

  // configuration
  logic [lss_pkg::REG_W-1:0] width_r, height_r;

  // current segment
  logic [C-1:0] x1_r, y1_r, x2_r, y2_r;
  logic signed [lss_pkg::D_W-1:0] dx_r, dy_r;
  logic left_r, right_r;

  // shared multiplier
  logic signed [lss_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [lss_pkg::PROD_W-1:0] prod_r;

  // distance terms
  logic signed [lss_pkg::CR_W:0]   t_r;
  logic [lss_pkg::CR_W-1:0]        c_r;
  logic [lss_pkg::LEN_W-1:0]       len_r;
  logic [lss_pkg::SQ_W-1:0]        sqa_r, sqb_r;
  logic [lss_pkg::ACC_W-1:0]       acca_r, accb_r;

  // per-side best
  logic [lss_pkg::SEG_W-1:0]       lseg_r, rseg_r;
  logic [lss_pkg::CR_W-1:0]        lcross_r, rcross_r;
  logic [lss_pkg::LEN_W-1:0]       llen_r, rlen_r;
  logic                            lhave_r, rhave_r;

  // result register
  logic                            out_valid_r;
  logic [lss_pkg::OUT_DATA_W-1:0]  out_data_r;

  // input fields
  logic [C-1:0] in_x1, in_y1, in_x2, in_y2;
  logic         in_acc, out_free;

  assign in_x1 = in_tdata[C-1:0];
  assign in_y1 = in_tdata[2*C-1:C];
  assign in_x2 = in_tdata[3*C-1:2*C];
  assign in_y2 = in_tdata[4*C-1:3*C];

  assign in_tready  = (state_r == lss_pkg::ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;

  // Left quarter: 4x < w. Right quarter: 4x > 3w.
  logic [lss_pkg::CMP_W-1:0] w_ext, w3, q1, q2;
  logic in_left, in_right;

  assign w_ext    = lss_pkg::CMP_W'(width_r);
  assign w3       = w_ext + (w_ext << 1);
  assign q1       = lss_pkg::CMP_W'(in_x1) << 2;
  assign q2       = lss_pkg::CMP_W'(in_x2) << 2;
  assign in_left  = (q1 < w_ext) || (q2 < w_ext);
  assign in_right = (q1 > w3) || (q2 > w3);

  // Centered doubled endpoints relative to the bottom-center point
  logic signed [lss_pkg::X_W-1:0] ax, ay, bx, by, w_s, h2_s;

  assign w_s  = signed'(lss_pkg::X_W'(width_r));
  assign h2_s = signed'(lss_pkg::X_W'(height_r) << 1);
  assign ax   = signed'(lss_pkg::X_W'(x1_r) << 1) - w_s;
  assign ay   = signed'(lss_pkg::X_W'(y1_r) << 1) - h2_s;
  assign bx   = signed'(lss_pkg::X_W'(x2_r) << 1) - w_s;
  assign by   = signed'(lss_pkg::X_W'(y2_r) << 1) - h2_s;

  // Slope above 0.2 on its side, divided through by |dx|: side * 5*dy*sgn(dx) > |dx|
  logic signed [lss_pkg::SL_W-1:0] dy5, s_term, adx;
  logic dx_nz, slope_ok, drop;

  assign dx_nz  = (dx_r != '0);
  assign dy5    = (lss_pkg::SL_W'(dy_r) <<< 2) + lss_pkg::SL_W'(dy_r);
  assign s_term = dx_r[lss_pkg::D_W-1] ? -dy5 : dy5;
  assign adx    = dx_r[lss_pkg::D_W-1] ? -lss_pkg::SL_W'(dx_r) : lss_pkg::SL_W'(dx_r);
  assign slope_ok = left_r ? (-s_term > adx) : (s_term > adx);

  assign drop = (!left_r && !right_r)
             || (dx_nz && left_r && right_r)
             || (dx_nz && !slope_ok)
             || (!dx_nz && (dy_r == '0))
             || ((ax == '0) && (ay == '0))
             || ((bx == '0) && (by == '0));

  // Values of the side the segment goes to
  logic [lss_pkg::CR_W-1:0]  best_c;
  logic [lss_pkg::LEN_W-1:0] best_l;
  logic                      best_have, closer;

  assign best_c    = left_r ? lcross_r : rcross_r;
  assign best_l    = left_r ? llen_r : rlen_r;
  assign best_have = left_r ? lhave_r : rhave_r;
  assign closer    = acca_r < accb_r;

  // cross = ax*by - ay*bx
  logic signed [lss_pkg::CR_W:0] cr_diff;
  assign cr_diff = t_r - prod_r[lss_pkg::CR_W:0];

  // Pick the shared multiplier's operands for each step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      lss_pkg::ST_SEL: begin
        mul_a = lss_pkg::MUL_W'(ax);
        mul_b = lss_pkg::MUL_W'(by);
      end
      lss_pkg::ST_CR0: begin
        mul_a = lss_pkg::MUL_W'(ay);
        mul_b = lss_pkg::MUL_W'(bx);
      end
      lss_pkg::ST_CR1: begin
        mul_a = lss_pkg::MUL_W'(dx_r);
        mul_b = lss_pkg::MUL_W'(dx_r);
      end
      lss_pkg::ST_LEN0: begin
        mul_a = lss_pkg::MUL_W'(dy_r);
        mul_b = lss_pkg::MUL_W'(dy_r);
      end
      lss_pkg::ST_LEN1: begin
        mul_a = signed'({1'b0, c_r});
        mul_b = signed'({1'b0, c_r});
      end
      lss_pkg::ST_SQ0: begin
        mul_a = signed'({1'b0, best_c});
        mul_b = signed'({1'b0, best_c});
      end
      lss_pkg::ST_SQ1: begin
        mul_a = signed'(lss_pkg::MUL_W'(sqa_r[lss_pkg::HALF_W-1:0]));
        mul_b = signed'(lss_pkg::MUL_W'(best_l));
      end
      lss_pkg::ST_PA0: begin
        mul_a = signed'(lss_pkg::MUL_W'(sqa_r[lss_pkg::SQ_W-1:lss_pkg::HALF_W]));
        mul_b = signed'(lss_pkg::MUL_W'(best_l));
      end
      lss_pkg::ST_PA1: begin
        mul_a = signed'(lss_pkg::MUL_W'(sqb_r[lss_pkg::HALF_W-1:0]));
        mul_b = signed'(lss_pkg::MUL_W'(len_r));
      end
      lss_pkg::ST_PB0: begin
        mul_a = signed'(lss_pkg::MUL_W'(sqb_r[lss_pkg::SQ_W-1:lss_pkg::HALF_W]));
        mul_b = signed'(lss_pkg::MUL_W'(len_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lss_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? lss_pkg::ST_FLUSH : lss_pkg::ST_SEL;
        end
      end
      lss_pkg::ST_SEL:    state_nxt = drop ? lss_pkg::ST_IDLE : lss_pkg::ST_CR0;
      lss_pkg::ST_CR0:    state_nxt = lss_pkg::ST_CR1;
      lss_pkg::ST_CR1:    state_nxt = lss_pkg::ST_LEN0;
      lss_pkg::ST_LEN0:   state_nxt = lss_pkg::ST_LEN1;
      lss_pkg::ST_LEN1:   state_nxt = lss_pkg::ST_SQ0;
      lss_pkg::ST_SQ0:    state_nxt = lss_pkg::ST_SQ1;
      lss_pkg::ST_SQ1:    state_nxt = lss_pkg::ST_PA0;
      lss_pkg::ST_PA0:    state_nxt = lss_pkg::ST_PA1;
      lss_pkg::ST_PA1:    state_nxt = lss_pkg::ST_PB0;
      lss_pkg::ST_PB0:    state_nxt = lss_pkg::ST_PB1;
      lss_pkg::ST_PB1:    state_nxt = lss_pkg::ST_DECIDE;
      lss_pkg::ST_DECIDE: state_nxt = lss_pkg::ST_IDLE;
      lss_pkg::ST_FLUSH: begin
        if (out_free) begin
          state_nxt = lss_pkg::ST_IDLE;
        end
      end
      default:            state_nxt = lss_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= lss_pkg::FRAME_WIDTH_RST;
      height_r <= lss_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == lss_pkg::CFG_FRAME_WIDTH) begin
        width_r <= cfg_data;
      end
      if (cfg_index == lss_pkg::CFG_FRAME_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  // Datapath: capture the segment, then walk the products through the shared unit
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      x1_r    <= in_x1;
      y1_r    <= in_y1;
      x2_r    <= in_x2;
      y2_r    <= in_y2;
      dx_r    <= signed'(lss_pkg::D_W'(in_x1)) - signed'(lss_pkg::D_W'(in_x2));
      dy_r    <= signed'(lss_pkg::D_W'(in_y1)) - signed'(lss_pkg::D_W'(in_y2));
      left_r  <= in_left;
      right_r <= in_right;
    end
    unique case (state_r)
      lss_pkg::ST_CR0:  t_r    <= prod_r[lss_pkg::CR_W:0];
      lss_pkg::ST_CR1:  c_r    <= cr_diff[lss_pkg::CR_W] ? lss_pkg::CR_W'(-cr_diff)
                                                         : lss_pkg::CR_W'(cr_diff);
      lss_pkg::ST_LEN0: len_r  <= prod_r[lss_pkg::LEN_W-1:0];
      lss_pkg::ST_LEN1: len_r  <= len_r + prod_r[lss_pkg::LEN_W-1:0];
      lss_pkg::ST_SQ0:  sqa_r  <= prod_r[lss_pkg::SQ_W-1:0];
      lss_pkg::ST_SQ1:  sqb_r  <= prod_r[lss_pkg::SQ_W-1:0];
      lss_pkg::ST_PA0:  acca_r <= lss_pkg::ACC_W'(prod_r[lss_pkg::PP_W-1:0]);
      lss_pkg::ST_PA1:  acca_r <= acca_r + {prod_r[lss_pkg::PP_W-1:0],
                                            {lss_pkg::HALF_W{1'b0}}};
      lss_pkg::ST_PB0:  accb_r <= lss_pkg::ACC_W'(prod_r[lss_pkg::PP_W-1:0]);
      lss_pkg::ST_PB1:  accb_r <= accb_r + {prod_r[lss_pkg::PP_W-1:0],
                                            {lss_pkg::HALF_W{1'b0}}};
      default: ;
    endcase
  end

  // Per-side best; the first minimum stays, a strictly closer one replaces it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhave_r <= 1'b0;
      rhave_r <= 1'b0;
    end else if (state_r == lss_pkg::ST_FLUSH && out_free) begin
      lhave_r <= 1'b0;
      rhave_r <= 1'b0;
    end else if (state_r == lss_pkg::ST_DECIDE && (!best_have || closer)) begin
      if (left_r) begin
        lseg_r   <= {x1_r, y1_r, x2_r, y2_r};
        lcross_r <= c_r;
        llen_r   <= len_r;
        lhave_r  <= 1'b1;
      end else begin
        rseg_r   <= {x1_r, y1_r, x2_r, y2_r};
        rcross_r <= c_r;
        rlen_r   <= len_r;
        rhave_r  <= 1'b1;
      end
    end
  end

  // Result word: each side's fields are zero when nothing was chosen
  logic [lss_pkg::SEG_W-1:0] lseg_o, rseg_o;

  assign lseg_o = lhave_r ? lseg_r : '0;
  assign rseg_o = rhave_r ? rseg_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == lss_pkg::ST_FLUSH && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lss_pkg::ST_FLUSH && out_free) begin
      out_data_r <= lss_pkg::OUT_DATA_W'({
        rseg_o[C-1:0], rseg_o[2*C-1:C], rseg_o[3*C-1:2*C], rseg_o[4*C-1:3*C], rhave_r,
        lseg_o[C-1:0], lseg_o[2*C-1:C], lseg_o[3*C-1:2*C], lseg_o[4*C-1:3*C], lhave_r
      });
    end
  end

endmodule
